// File: design/trcc_pkg.sv
package trcc_pkg;

  localparam int WORD_W            = 16;
  localparam int ADDR_W            = 15;
  localparam int COMP_W            = 7;
  localparam int RAM_DEPTH_DEFAULT = 32768;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_EXEC   = 2'd0,
    OP_HWRITE = 2'd1,
    OP_HREAD  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  // Compute codes: the a bit followed by c1..c6.
  localparam logic [COMP_W-1:0] COMP_ZERO    = 7'h2A;
  localparam logic [COMP_W-1:0] COMP_ONE     = 7'h3F;
  localparam logic [COMP_W-1:0] COMP_MINUS1  = 7'h3A;
  localparam logic [COMP_W-1:0] COMP_D       = 7'h0C;
  localparam logic [COMP_W-1:0] COMP_A       = 7'h30;
  localparam logic [COMP_W-1:0] COMP_NOT_D   = 7'h0D;
  localparam logic [COMP_W-1:0] COMP_NOT_A   = 7'h31;
  localparam logic [COMP_W-1:0] COMP_NEG_D   = 7'h0F;
  localparam logic [COMP_W-1:0] COMP_NEG_A   = 7'h33;
  localparam logic [COMP_W-1:0] COMP_D_INC   = 7'h1F;
  localparam logic [COMP_W-1:0] COMP_A_INC   = 7'h37;
  localparam logic [COMP_W-1:0] COMP_D_DEC   = 7'h0E;
  localparam logic [COMP_W-1:0] COMP_A_DEC   = 7'h32;
  localparam logic [COMP_W-1:0] COMP_D_ADD_A = 7'h02;
  localparam logic [COMP_W-1:0] COMP_D_SUB_A = 7'h13;
  localparam logic [COMP_W-1:0] COMP_A_SUB_D = 7'h07;
  localparam logic [COMP_W-1:0] COMP_D_AND_A = 7'h00;
  localparam logic [COMP_W-1:0] COMP_D_OR_A  = 7'h15;
  localparam logic [COMP_W-1:0] COMP_M       = 7'h70;
  localparam logic [COMP_W-1:0] COMP_NOT_M   = 7'h71;
  localparam logic [COMP_W-1:0] COMP_NEG_M   = 7'h73;
  localparam logic [COMP_W-1:0] COMP_M_INC   = 7'h77;
  localparam logic [COMP_W-1:0] COMP_M_DEC   = 7'h72;
  localparam logic [COMP_W-1:0] COMP_D_ADD_M = 7'h42;
  localparam logic [COMP_W-1:0] COMP_D_SUB_M = 7'h53;
  localparam logic [COMP_W-1:0] COMP_M_SUB_D = 7'h47;
  localparam logic [COMP_W-1:0] COMP_D_AND_M = 7'h40;
  localparam logic [COMP_W-1:0] COMP_D_OR_M  = 7'h55;

  // Write request from the execute stage to the data memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

endpackage

// File: design/two_register_cpu_core.sv
// Channel   Direction  Payload
// s_axis    in         tuser: opcode; tdata: instruction_word, host_address, host_data
// m_axis    out        tdata: next_pc, alu_result, a_value, d_value, memory_written,
//                      host_read_data
//
// One item per clock is accepted while m_axis is not stalled. The data memory read for
// an item is issued at its transfer edge; the execute stage finishes it once the output
// register is free, and its result is registered onto m_axis. After reset the memory is
// swept clear, one word per cycle, over all RAM_DEPTH words, while s_axis_tready stays
// low. A stalled m_axis holds the execute stage and, in turn, s_axis; the output register
// lets a new item enter while the previous result waits.
module two_register_cpu_core #(
  parameter int RAM_DEPTH = trcc_pkg::RAM_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] instruction_word, [30:16] host_address, [46:31] host_data, [47] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] next_pc, [30:15] alu_result, [46:31] a_value, [62:47] d_value,
  // [63] memory_written, [79:64] host_read_data
  output logic [79:0] m_axis_tdata
);

  localparam int WW = trcc_pkg::WORD_W;
  localparam int AW = trcc_pkg::ADDR_W;

  // Architectural registers. A, D and the program counter live in flops; M is in the data memory.
  logic [WW-1:0] a_reg;
  logic [WW-1:0] d_reg;
  logic [AW-1:0] pc;

  // Execute stage: the item accepted on the previous transfer, its memory word
  // arriving from the synchronous read.
  logic              s1_valid;
  trcc_pkg::opcode_t s1_op;
  logic [WW-1:0]     s1_instr;
  logic [AW-1:0]     s1_haddr;
  logic [WW-1:0]     s1_hdata;

  logic          out_valid;
  logic [79:0]   out_data;

  logic          out_free;
  logic          s1_done;
  logic          in_accept;
  logic          ram_busy;
  logic [AW-1:0] rd_addr;
  logic [WW-1:0] m_word;
  logic [WW-1:0] alu_y;

  logic          is_exec;
  logic          is_cinst;
  logic [WW-1:0] a_next;
  logic [WW-1:0] d_next;
  logic [AW-1:0] pc_next;
  logic [WW-1:0] comp_val;
  logic [WW-1:0] host_rd;
  logic          jump;
  logic          wr_req;
  logic          wr_in_range;
  logic [AW-1:0] a_fwd_addr;

  trcc_pkg::ram_wr_t ram_wr;

  assign out_free      = !out_valid || m_axis_tready;
  assign s1_done       = s1_valid && out_free;
  assign s_axis_tready = !ram_busy && (!s1_valid || out_free);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  trcc_alu u_alu (
    .comp (s1_instr[12:6]),
    .d    (d_reg),
    .a    (a_reg),
    .m    (m_word),
    .y    (alu_y)
  );

  // Execute stage logic. Memory and jump use A as it was before this instruction.
  always_comb begin
    is_exec  = (s1_op == trcc_pkg::OP_EXEC);
    is_cinst = is_exec && s1_instr[15];
    comp_val = is_cinst ? alu_y : '0;

    if (is_exec && !s1_instr[15]) begin
      a_next = s1_instr;
    end else if (is_cinst && s1_instr[5]) begin
      a_next = alu_y;
    end else begin
      a_next = a_reg;
    end

    d_next = (is_cinst && s1_instr[4]) ? alu_y : d_reg;

    jump = (s1_instr[2] && alu_y[WW-1]) ||
           (s1_instr[1] && (alu_y == '0)) ||
           (s1_instr[0] && !alu_y[WW-1] && (alu_y != '0));

    if (is_cinst && jump) begin
      pc_next = a_reg[AW-1:0];
    end else if (is_exec) begin
      pc_next = pc + 1'b1;
    end else begin
      pc_next = pc;
    end

    host_rd = (s1_op == trcc_pkg::OP_HREAD) ? m_word : '0;

    if (s1_op == trcc_pkg::OP_HWRITE) begin
      wr_req       = 1'b1;
      ram_wr.addr  = s1_haddr;
      ram_wr.data  = s1_hdata;
    end else begin
      wr_req       = is_cinst && s1_instr[3];
      ram_wr.addr  = a_reg[AW-1:0];
      ram_wr.data  = alu_y;
    end
    wr_in_range = ({1'b0, ram_wr.addr} < 16'(RAM_DEPTH));
    ram_wr.en   = s1_done && wr_req && wr_in_range;
  end

  // The read for the incoming item uses A as the finishing item leaves it.
  always_comb begin
    a_fwd_addr = s1_done ? a_next[AW-1:0] : a_reg[AW-1:0];
    if (trcc_pkg::opcode_t'(s_axis_tuser) == trcc_pkg::OP_EXEC) begin
      rd_addr = a_fwd_addr;
    end else begin
      rd_addr = s_axis_tdata[30:16];
    end
  end

  trcc_ram #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (m_word),
    .wr      (ram_wr),
    .busy    (ram_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_reg <= '0;
      d_reg <= '0;
      pc    <= '0;
    end else if (s1_done) begin
      a_reg <= a_next;
      d_reg <= d_next;
      pc    <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op    <= trcc_pkg::opcode_t'(s_axis_tuser);
      s1_instr <= s_axis_tdata[15:0];
      s1_haddr <= s_axis_tdata[30:16];
      s1_hdata <= s_axis_tdata[46:31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_data <= {host_rd, ram_wr.en, d_next, a_next, comp_val, pc_next};
    end
  end

`ifndef ASSERT_OFF
  // Nothing reaches the output while the memory is still being cleared.
  assert property (@(posedge clk) disable iff (rst) ram_busy |-> !m_axis_tvalid)
    else $error("result presented during memory clear");

  // Memory writes come only from an item finishing execute.
  assert property (@(posedge clk) disable iff (rst) ram_wr.en |-> s1_done)
    else $error("memory write without a finishing item");

  // A held result with a full execute stage must stall the input.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready && s1_valid) |-> !s_axis_tready)
    else $error("input accepted while pipeline is full");

  // An address load leaves A equal to the instruction word.
  assert property (@(posedge clk) disable iff (rst)
    (s1_done && (s1_op == trcc_pkg::OP_EXEC) && !s1_instr[15]) |=>
      (a_reg == $past(s1_instr)))
    else $error("address load did not reach A");

  // The program counter moves only when an execute item finishes.
  assert property (@(posedge clk) disable iff (rst)
    !(s1_done && (s1_op == trcc_pkg::OP_EXEC)) |=> $stable(pc))
    else $error("program counter changed without an execute item");
`endif

endmodule

// File: design/trcc_alu.sv
module trcc_alu (
  input  logic [trcc_pkg::COMP_W-1:0] comp,
  input  logic [trcc_pkg::WORD_W-1:0] d,
  input  logic [trcc_pkg::WORD_W-1:0] a,
  input  logic [trcc_pkg::WORD_W-1:0] m,
  output logic [trcc_pkg::WORD_W-1:0] y
);

  always_comb begin
    case (comp)
      trcc_pkg::COMP_ZERO:    y = '0;
      trcc_pkg::COMP_ONE:     y = 16'd1;
      trcc_pkg::COMP_MINUS1:  y = '1;
      trcc_pkg::COMP_D:       y = d;
      trcc_pkg::COMP_A:       y = a;
      trcc_pkg::COMP_NOT_D:   y = ~d;
      trcc_pkg::COMP_NOT_A:   y = ~a;
      trcc_pkg::COMP_NEG_D:   y = 16'd0 - d;
      trcc_pkg::COMP_NEG_A:   y = 16'd0 - a;
      trcc_pkg::COMP_D_INC:   y = d + 16'd1;
      trcc_pkg::COMP_A_INC:   y = a + 16'd1;
      trcc_pkg::COMP_D_DEC:   y = d - 16'd1;
      trcc_pkg::COMP_A_DEC:   y = a - 16'd1;
      trcc_pkg::COMP_D_ADD_A: y = d + a;
      trcc_pkg::COMP_D_SUB_A: y = d - a;
      trcc_pkg::COMP_A_SUB_D: y = a - d;
      trcc_pkg::COMP_D_AND_A: y = d & a;
      trcc_pkg::COMP_D_OR_A:  y = d | a;
      trcc_pkg::COMP_M:       y = m;
      trcc_pkg::COMP_NOT_M:   y = ~m;
      trcc_pkg::COMP_NEG_M:   y = 16'd0 - m;
      trcc_pkg::COMP_M_INC:   y = m + 16'd1;
      trcc_pkg::COMP_M_DEC:   y = m - 16'd1;
      trcc_pkg::COMP_D_ADD_M: y = d + m;
      trcc_pkg::COMP_D_SUB_M: y = d - m;
      trcc_pkg::COMP_M_SUB_D: y = m - d;
      trcc_pkg::COMP_D_AND_M: y = d & m;
      trcc_pkg::COMP_D_OR_M:  y = d | m;
      default:                y = '0;
    endcase
  end

endmodule

// File: design/trcc_ram.sv
module trcc_ram #(
  parameter int RAM_DEPTH = trcc_pkg::RAM_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [trcc_pkg::ADDR_W-1:0] rd_addr,
  output logic [trcc_pkg::WORD_W-1:0] rd_data,
  input  trcc_pkg::ram_wr_t           wr,
  output logic                        busy
);

  localparam int RAM_AW = $clog2(RAM_DEPTH);

  logic [trcc_pkg::WORD_W-1:0] mem [RAM_DEPTH];
  logic [trcc_pkg::WORD_W-1:0] mem_q;
  logic                        rd_in_range;
  logic                        byp_hit;
  logic [trcc_pkg::WORD_W-1:0] byp_data;
  logic [RAM_AW-1:0]           clr_cnt;
  logic                        mem_we;
  logic [RAM_AW-1:0]           mem_waddr;
  logic [trcc_pkg::WORD_W-1:0] mem_wdata;

  // The clearing sweep owns the write port until it finishes.
  always_comb begin
    mem_we    = busy | wr.en;
    mem_waddr = busy ? clr_cnt : wr.addr[RAM_AW-1:0];
    mem_wdata = busy ? '0 : wr.data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr[RAM_AW-1:0]];
    end
  end

  // A write landing on the entry read at the same edge is forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit     <= 1'b0;
      rd_in_range <= 1'b0;
    end else if (rd_en) begin
      byp_hit     <= wr.en && (wr.addr == rd_addr);
      rd_in_range <= ({1'b0, rd_addr} < 16'(RAM_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr.data;
    end
  end

  always_comb begin
    if (byp_hit) begin
      rd_data = byp_data;
    end else if (rd_in_range) begin
      rd_data = mem_q;
    end else begin
      rd_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == RAM_AW'(RAM_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: verif/tb_two_register_cpu_core.sv
`default_nettype none

// The core runs as a stream: every input transfer carries one item and produces exactly one
// output transfer. The bench keeps its own copy of A, D, the program counter and the data
// RAM, computes the output of every accepted item, and compares it field by field with
// what the core hands out, in order.
module tb_two_register_cpu_core;
  timeunit 1ns;
  timeprecision 1ps;

  import trcc_pkg::*;

  localparam int RAM_WORDS    = RAM_DEPTH_DEFAULT;
  localparam int MAX_GAP      = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 8;

  // Destination and jump fields of a compute instruction.
  localparam logic [2:0] DEST_NONE = 3'b000;
  localparam logic [2:0] DEST_M    = 3'b001;
  localparam logic [2:0] DEST_D    = 3'b010;
  localparam logic [2:0] DEST_A    = 3'b100;
  localparam logic [2:0] JMP_NONE  = 3'b000;
  localparam logic [2:0] JMP_GT    = 3'b001;
  localparam logic [2:0] JMP_EQ    = 3'b010;
  localparam logic [2:0] JMP_LT    = 3'b100;
  localparam logic [2:0] JMP_ALL   = 3'b111;

  // A compute code that names no ALU function.
  localparam logic [COMP_W-1:0] COMP_UNUSED = 7'h7F;

  typedef struct {
    opcode_t           op;
    logic [WORD_W-1:0] instr;
    logic [ADDR_W-1:0] haddr;
    logic [WORD_W-1:0] hdata;
    int unsigned       gap;
  } cpu_item_t;

  typedef struct {
    logic [ADDR_W-1:0] next_pc;
    logic [WORD_W-1:0] alu_result;
    logic [WORD_W-1:0] a_value;
    logic [WORD_W-1:0] d_value;
    logic              mem_wr;
    logic [WORD_W-1:0] read_data;
  } cpu_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [15:0] instruction_word, [30:16] host_address, [46:31] host_data, [47] zero
  logic [47:0] s_axis_tdata = '0;
  // [1:0] opcode
  logic [1:0]  s_axis_tuser = OP_NOP;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [14:0] next_pc, [30:15] alu_result, [46:31] a_value, [62:47] d_value,
  // [63] memory_written, [79:64] host_read_data
  logic [79:0] m_axis_tdata;

  // Items still waiting to be offered, and results the core still owes us.
  cpu_item_t   instr_queue[$];
  cpu_result_t result_queue[$];

  // Shadow machine state.
  logic [WORD_W-1:0] model_a;
  logic [WORD_W-1:0] model_d;
  logic [ADDR_W-1:0] model_pc;
  logic [WORD_W-1:0] model_ram [RAM_WORDS];

  int          errors = 0;
  bit          burst_mode = 1'b0;
  bit          no_stall_mode = 1'b0;
  int unsigned idle_count = 0;
  int unsigned stall_count = 0;
  int unsigned results_seen = 0;
  cpu_item_t   current_item;

  two_register_cpu_core #(
    .RAM_DEPTH(RAM_WORDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // ALU of the compute instruction; every result is cut to 16 bits by the return type.
  function automatic logic [WORD_W-1:0] alu_eval(input logic [COMP_W-1:0] code,
                                                 input logic [WORD_W-1:0] d,
                                                 input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] m);
    case (code)
      COMP_ZERO:    return 16'h0000;
      COMP_ONE:     return 16'h0001;
      COMP_MINUS1:  return 16'hFFFF;
      COMP_D:       return d;
      COMP_A:       return a;
      COMP_NOT_D:   return ~d;
      COMP_NOT_A:   return ~a;
      COMP_NEG_D:   return 16'd0 - d;
      COMP_NEG_A:   return 16'd0 - a;
      COMP_D_INC:   return d + 16'd1;
      COMP_A_INC:   return a + 16'd1;
      COMP_D_DEC:   return d - 16'd1;
      COMP_A_DEC:   return a - 16'd1;
      COMP_D_ADD_A: return d + a;
      COMP_D_SUB_A: return d - a;
      COMP_A_SUB_D: return a - d;
      COMP_D_AND_A: return d & a;
      COMP_D_OR_A:  return d | a;
      COMP_M:       return m;
      COMP_NOT_M:   return ~m;
      COMP_NEG_M:   return 16'd0 - m;
      COMP_M_INC:   return m + 16'd1;
      COMP_M_DEC:   return m - 16'd1;
      COMP_D_ADD_M: return d + m;
      COMP_D_SUB_M: return d - m;
      COMP_M_SUB_D: return m - d;
      COMP_D_AND_M: return d & m;
      COMP_D_OR_M:  return d | m;
      default:      return 16'h0000;
    endcase
  endfunction

  // Words past the end of the RAM read as zero and swallow writes.
  function automatic logic [WORD_W-1:0] ram_read(input logic [ADDR_W-1:0] addr);
    if (int'(addr) >= RAM_WORDS) return '0;
    return model_ram[addr];
  endfunction

  function automatic bit ram_write(input logic [ADDR_W-1:0] addr,
                                   input logic [WORD_W-1:0] data);
    if (int'(addr) >= RAM_WORDS) return 1'b0;
    model_ram[addr] = data;
    return 1'b1;
  endfunction

  // Advances the shadow state by one item and queues the output it must produce.
  task automatic predict_cpu(input cpu_item_t it);
    cpu_result_t       res;
    logic [WORD_W-1:0] a_old;
    logic [WORD_W-1:0] comp;
    logic [ADDR_W-1:0] pc_next;
    logic              neg;
    logic              zero;
    logic              pos;
    res.mem_wr = 1'b0;
    res.read_data = '0;
    comp = '0;
    case (it.op)
      OP_EXEC: begin
        // Memory address and jump target both use A as it was before any store.
        a_old = model_a;
        pc_next = model_pc + 1'b1;
        if (!it.instr[15]) begin
          model_a = it.instr;
        end else begin
          comp = alu_eval(it.instr[12:6], model_d, a_old, ram_read(a_old[ADDR_W-1:0]));
          if (it.instr[3]) res.mem_wr = ram_write(a_old[ADDR_W-1:0], comp);
          if (it.instr[4]) model_d = comp;
          if (it.instr[5]) model_a = comp;
          neg = comp[15];
          zero = (comp == '0);
          pos = !neg && !zero;
          if ((it.instr[2] && neg) || (it.instr[1] && zero) || (it.instr[0] && pos)) begin
            pc_next = a_old[ADDR_W-1:0];
          end
        end
        model_pc = pc_next;
      end
      OP_HWRITE: res.mem_wr = ram_write(it.haddr, it.hdata);
      OP_HREAD:  res.read_data = ram_read(it.haddr);
      default:   ;
    endcase
    res.next_pc = model_pc;
    res.alu_result = comp;
    res.a_value = model_a;
    res.d_value = model_d;
    result_queue.push_back(res);
  endtask

  task automatic check_field(input string fname, input logic [WORD_W-1:0] exp_val,
                             input logic [WORD_W-1:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, fname, exp_val,
                 act_val);
      end
    end
  endtask

  task automatic check_result(input logic [79:0] word);
    cpu_result_t exp_res;
    if (result_queue.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("[%0t] result transfer with nothing expected: %h", $realtime, word);
      end
    end else begin
      exp_res = result_queue.pop_front();
      check_field("next_pc", WORD_W'(exp_res.next_pc), WORD_W'(word[14:0]));
      check_field("alu_result", exp_res.alu_result, word[30:15]);
      check_field("a_value", exp_res.a_value, word[46:31]);
      check_field("d_value", exp_res.d_value, word[62:47]);
      check_field("memory_written", WORD_W'(exp_res.mem_wr), WORD_W'(word[63]));
      check_field("host_read_data", exp_res.read_data, word[79:64]);
    end
  endtask

  // Driver. Before each item it idles for the number of cycles that item carries. A valid
  // that is not yet taken is left alone; once the slot is free the next item goes out.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      idle_count = 0;
      model_a = '0;
      model_d = '0;
      model_pc = '0;
      foreach (model_ram[i]) model_ram[i] = '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_cpu(current_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (instr_queue.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (idle_count < instr_queue[0].gap) begin
          idle_count++;
          s_axis_tvalid <= 1'b0;
        end else begin
          current_item = instr_queue.pop_front();
          idle_count = 0;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= current_item.op;
          s_axis_tdata <= {1'b0, current_item.hdata, current_item.haddr, current_item.instr};
        end
      end
    end
  end

  // Monitor. Each result transfer is checked, then the receiver stalls for a random
  // number of cycles; now and then a run of results is taken with no stall at all.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
        results_seen++;
        if (results_seen % 40 == 0) no_stall_mode = ($urandom_range(0, 3) == 0);
        stall_count = no_stall_mode ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_count > 0) begin
        stall_count--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_item(input opcode_t op, input logic [WORD_W-1:0] instr,
                           input logic [ADDR_W-1:0] haddr, input logic [WORD_W-1:0] hdata);
    cpu_item_t it;
    it.op = op;
    it.instr = instr;
    it.haddr = haddr;
    it.hdata = hdata;
    it.gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    instr_queue.push_back(it);
  endtask

  // Compute instruction with bits 14 and 13 given by spare.
  function automatic logic [WORD_W-1:0] c_word(input logic [COMP_W-1:0] comp,
                                               input logic [2:0] dest, input logic [2:0] jmp,
                                               input logic [1:0] spare);
    return {1'b1, spare, comp, dest, jmp};
  endfunction

  function automatic logic [COMP_W-1:0] valid_comp(input int unsigned idx);
    case (idx)
      0:  return COMP_ZERO;
      1:  return COMP_ONE;
      2:  return COMP_MINUS1;
      3:  return COMP_D;
      4:  return COMP_A;
      5:  return COMP_NOT_D;
      6:  return COMP_NOT_A;
      7:  return COMP_NEG_D;
      8:  return COMP_NEG_A;
      9:  return COMP_D_INC;
      10: return COMP_A_INC;
      11: return COMP_D_DEC;
      12: return COMP_A_DEC;
      13: return COMP_D_ADD_A;
      14: return COMP_D_SUB_A;
      15: return COMP_A_SUB_D;
      16: return COMP_D_AND_A;
      17: return COMP_D_OR_A;
      18: return COMP_M;
      19: return COMP_NOT_M;
      20: return COMP_NEG_M;
      21: return COMP_M_INC;
      22: return COMP_M_DEC;
      23: return COMP_D_ADD_M;
      24: return COMP_D_SUB_M;
      25: return COMP_M_SUB_D;
      26: return COMP_D_AND_M;
      default: return COMP_D_OR_M;
    endcase
  endfunction

  // Addresses mostly come from two small windows at the bottom and top of the RAM so
  // that loads through M see words that earlier items stored.
  function automatic logic [ADDR_W-1:0] pick_addr();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return ADDR_W'($urandom_range(0, 15));
    if (sel < 8) return ADDR_W'(15'h7FF0 + $urandom_range(0, 15));
    return ADDR_W'($urandom());
  endfunction

  initial begin
    int unsigned kind;
    logic [COMP_W-1:0] comp;

    // Directed part: extremes, wraparound of the program counter, jumps on each sign,
    // an unused compute code, ignored bits 14 and 13, a no-op and both host items.
    push_item(OP_EXEC, 16'h7FFF, '0, '0);
    push_item(OP_HWRITE, 16'hFFFF, 15'h7FFF, 16'hFFFF);
    push_item(OP_EXEC, c_word(COMP_M, DEST_D, JMP_NONE, 2'b11), '0, '0);
    push_item(OP_EXEC, c_word(COMP_D_INC, DEST_M, JMP_EQ, 2'b11), '0, '0);
    push_item(OP_EXEC, 16'h0000, 15'h7FFF, 16'hFFFF);
    push_item(OP_HREAD, '0, 15'h7FFF, '0);
    push_item(OP_HWRITE, '0, 15'h0000, 16'h8000);
    push_item(OP_EXEC, c_word(COMP_M, DEST_A | DEST_D, JMP_LT, 2'b11), '0, '0);
    push_item(OP_EXEC, c_word(COMP_A_DEC, DEST_D, JMP_GT, 2'b00), '0, '0);
    push_item(OP_EXEC, c_word(COMP_UNUSED, DEST_A | DEST_D | DEST_M, JMP_ALL, 2'b01), '0,
              '0);
    push_item(OP_NOP, 16'hFFFF, 15'h7FFF, 16'hFFFF);
    push_item(OP_EXEC, 16'h0005, '0, '0);
    push_item(OP_EXEC, c_word(COMP_MINUS1, DEST_M, JMP_LT, 2'b10), '0, '0);
    push_item(OP_EXEC, c_word(COMP_ONE, DEST_D, JMP_GT, 2'b11), '0, '0);
    push_item(OP_EXEC, c_word(COMP_D_ADD_M, DEST_D, JMP_NONE, 2'b11), '0, '0);
    push_item(OP_EXEC, c_word(COMP_NEG_A, DEST_A, JMP_ALL, 2'b11), '0, '0);
    push_item(OP_EXEC, c_word(COMP_D_SUB_A, DEST_D | DEST_M, JMP_NONE, 2'b11), '0, '0);
    push_item(OP_EXEC, c_word(COMP_ZERO, DEST_A, JMP_EQ, 2'b11), '0, '0);
    push_item(OP_HREAD, '0, 15'h0000, '0);
    push_item(OP_EXEC, c_word(COMP_M_DEC, DEST_M, JMP_NONE, 2'b11), '0, '0);
    push_item(OP_EXEC, c_word(COMP_NOT_M, DEST_D, JMP_NONE, 2'b11), '0, '0);
    push_item(OP_EXEC, c_word(COMP_D_OR_A, DEST_NONE, JMP_ALL, 2'b11), '0, '0);
    push_item(OP_HWRITE, '0, 15'h0000, 16'h0000);

    // Random part: mostly loads of A and defined compute codes so that M, D and A
    // carry data from one instruction to the next; some host traffic and noise.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 33) begin
        if ($urandom_range(0, 4) == 0) push_item(OP_EXEC, {1'b0, 15'($urandom())},
                                                 15'($urandom()), 16'($urandom()));
        else push_item(OP_EXEC, {1'b0, pick_addr()}, 15'($urandom()), 16'($urandom()));
      end else if (kind < 80) begin
        comp = ($urandom_range(0, 99) < 85) ? valid_comp($urandom_range(0, 27))
                                            : COMP_W'($urandom());
        push_item(OP_EXEC, c_word(comp, 3'($urandom()), 3'($urandom()), 2'($urandom())),
                  15'($urandom()), 16'($urandom()));
      end else if (kind < 90) begin
        push_item(OP_HWRITE, 16'($urandom()), pick_addr(), 16'($urandom()));
      end else if (kind < 98) begin
        push_item(OP_HREAD, 16'($urandom()), pick_addr(), 16'($urandom()));
      end else begin
        push_item(OP_NOP, 16'($urandom()), 15'($urandom()), 16'($urandom()));
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The core first sweeps its RAM; the driver simply waits on tready through that.
    // Polling on the falling edge keeps this loop clear of the clocked blocks.
    while (instr_queue.size() != 0 || s_axis_tvalid || result_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && result_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: covers the RAM sweep plus every item at its longest gaps and stalls,
  // several times over.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
